/* rtl/svm_pkg.sv */
package svm_pkg;

  localparam int DATA_WORDS_DEF     = 256;
  localparam int STACK_DEPTH_DEF    = 256;
  localparam int REG_COUNT_DEF      = 8;
  localparam int FLAG_REG_INDEX_DEF = 0;
  localparam int PC_BITS_DEF        = 16;

  localparam logic [31:0] MANT_MASK = 32'h1FFF_FFFF;
  localparam int          EXP_SHIFT = 29;

  localparam logic [5:0] OP_NOP   = 6'd0;
  localparam logic [5:0] OP_MOV   = 6'd1;
  localparam logic [5:0] OP_ADD   = 6'd2;
  localparam logic [5:0] OP_SUB   = 6'd3;
  localparam logic [5:0] OP_NEG   = 6'd4;
  localparam logic [5:0] OP_MUL   = 6'd5;
  localparam logic [5:0] OP_DIV   = 6'd6;
  localparam logic [5:0] OP_DADD  = 6'd7;
  localparam logic [5:0] OP_DSUB  = 6'd8;
  localparam logic [5:0] OP_DMUL  = 6'd9;
  localparam logic [5:0] OP_DDIV  = 6'd10;
  localparam logic [5:0] OP_EQ    = 6'd11;
  localparam logic [5:0] OP_JMP   = 6'd12;
  localparam logic [5:0] OP_JMPC  = 6'd13;
  localparam logic [5:0] OP_PUSH  = 6'd14;
  localparam logic [5:0] OP_POP   = 6'd15;
  localparam logic [5:0] OP_PEEK  = 6'd16;
  localparam logic [5:0] OP_SFREE = 6'd17;
  localparam logic [5:0] OP_LAND  = 6'd18;
  localparam logic [5:0] OP_LOR   = 6'd19;
  localparam logic [5:0] OP_AND   = 6'd20;
  localparam logic [5:0] OP_OR    = 6'd21;
  localparam logic [5:0] OP_GT    = 6'd22;
  localparam logic [5:0] OP_GE    = 6'd23;
  localparam logic [5:0] OP_LT    = 6'd24;
  localparam logic [5:0] OP_LE    = 6'd25;
  localparam logic [5:0] OP_NE    = 6'd26;
  localparam logic [5:0] OP_PUTC  = 6'd27;
  localparam logic [5:0] OP_LNOT  = 6'd28;
  localparam logic [5:0] OP_SHL   = 6'd29;
  localparam logic [5:0] OP_SHR   = 6'd30;
  localparam logic [5:0] OP_NOT   = 6'd31;
  localparam logic [5:0] OP_DTOI  = 6'd32;
  localparam logic [5:0] OP_GSP   = 6'd33;
  localparam logic [5:0] OP_PUSHN = 6'd34;

  localparam logic [2:0] MODE_IMM  = 3'd0;
  localparam logic [2:0] MODE_MEM  = 3'd1;
  localparam logic [2:0] MODE_REG  = 3'd2;
  localparam logic [2:0] MODE_RMEM = 3'd3;
  localparam logic [2:0] MODE_STK  = 3'd4;
  localparam logic [2:0] MODE_RSTK = 3'd5;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_MODE  = 3'd1;
  localparam logic [2:0] ERR_OP    = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_OVF   = 3'd4;
  localparam logic [2:0] ERR_UNF   = 3'd5;
  localparam logic [2:0] ERR_RANGE = 3'd6;

  localparam logic [1:0] LOC_IMM  = 2'd0;
  localparam logic [1:0] LOC_DATA = 2'd1;
  localparam logic [1:0] LOC_REG  = 2'd2;
  localparam logic [1:0] LOC_STK  = 2'd3;

  // How the execute step continues after the S_EX state.
  localparam logic [2:0] K_SIMPLE = 3'd0;
  localparam logic [2:0] K_DIV    = 3'd1;
  localparam logic [2:0] K_DEC    = 3'd2;
  localparam logic [2:0] K_SRD    = 3'd3;
  localparam logic [2:0] K_PSH    = 3'd4;

  typedef struct packed {
    logic clr;
    logic load;
    logic dec;
    logic res;
    logic cap;
    logic sel_b;
    logic ex;
    logic div_step;
    logic fin2;
    logic srd;
    logic psh;
    logic wb;
    logic done;
  } svm_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       op_bad;
    logic       op_nop;
    logic       uses_b;
    logic       res_bad;
    logic       res_mem;
    logic [2:0] kind;
    logic       div_last;
    logic       psh_last;
    logic       out_busy;
  } svm_sts_t;

  function automatic logic writes_a(input logic [5:0] op);
    case (op) inside
      OP_NOP, OP_JMP, OP_JMPC, OP_PUSH, OP_SFREE, OP_PUTC, OP_PUSHN: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic reads_b(input logic [5:0] op);
    case (op) inside
      OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DADD, OP_DSUB, OP_DMUL, OP_DDIV,
      OP_EQ, OP_PEEK, OP_LAND, OP_LOR, OP_AND, OP_OR, OP_GT, OP_GE, OP_LT, OP_LE,
      OP_NE, OP_SHL, OP_SHR, OP_DTOI, OP_PUSHN: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] pow10(input logic [2:0] e);
    case (e)
      3'd0:    return 32'd1;
      3'd1:    return 32'd10;
      3'd2:    return 32'd100;
      3'd3:    return 32'd1000;
      3'd4:    return 32'd10000;
      3'd5:    return 32'd100000;
      3'd6:    return 32'd1000000;
      default: return 32'd10000000;
    endcase
  endfunction

endpackage

/* rtl/stack_vm_instruction_executor_core.sv */
// NOP and unknown codes go from decode straight to the result; other instructions resolve
// their operands (one extra load state per operand in data or stack memory), execute and
// write back; DIV, DDIV and DTOI use the 32-step shared divider, and PUSHN pushes one word
// per step for its count. One request is in flight at a time; the next is accepted once the
// result is registered. After reset the data memory is cleared, one word a cycle, before the
// first request is accepted; the stack memory is not cleared.
module stack_vm_instruction_executor_core #(
  parameter int DATA_WORDS     = svm_pkg::DATA_WORDS_DEF,
  parameter int STACK_DEPTH    = svm_pkg::STACK_DEPTH_DEF,
  parameter int REG_COUNT      = svm_pkg::REG_COUNT_DEF,
  parameter int FLAG_REG_INDEX = svm_pkg::FLAG_REG_INDEX_DEF,
  parameter int PC_BITS        = svm_pkg::PC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         command,
  input  logic [2:0]         dest_mode,
  input  logic signed [31:0] dest_operand,
  input  logic [2:0]         src_mode,
  input  logic signed [31:0] src_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        next_pc,
  output logic               char_valid,
  output logic [7:0]         char_out,
  output logic [2:0]         error_code
);
  import svm_pkg::*;

  svm_cmd_t cmd;
  svm_sts_t sts;

  svm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  svm_dp #(
    .DATA_WORDS(DATA_WORDS), .STACK_DEPTH(STACK_DEPTH), .REG_COUNT(REG_COUNT),
    .FLAG_REG_INDEX(FLAG_REG_INDEX), .PC_BITS(PC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .command(command), .dest_mode(dest_mode), .dest_operand(dest_operand),
    .src_mode(src_mode), .src_operand(src_operand),
    .out_valid(out_valid), .out_ready(out_ready), .next_pc(next_pc),
    .char_valid(char_valid), .char_out(char_out), .error_code(error_code)
  );
endmodule

/* rtl/svm_ram.sv */
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/svm_ctrl.sv */
module svm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  svm_pkg::svm_sts_t sts,
  output svm_pkg::svm_cmd_t cmd
);
  import svm_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_RA   = 4'd3;
  localparam logic [3:0] S_LA   = 4'd4;
  localparam logic [3:0] S_RB   = 4'd5;
  localparam logic [3:0] S_LB   = 4'd6;
  localparam logic [3:0] S_EX   = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN2 = 4'd9;
  localparam logic [3:0] S_SRD  = 4'd10;
  localparam logic [3:0] S_PSH  = 4'd11;
  localparam logic [3:0] S_WB   = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec    = 1'b1;
        state_next = (sts.op_bad || sts.op_nop) ? S_DONE : S_RA;
      end
      S_RA: begin
        cmd.res = 1'b1;
        if (sts.res_bad)      state_next = S_DONE;
        else if (sts.res_mem) state_next = S_LA;
        else if (sts.uses_b)  state_next = S_RB;
        else                  state_next = S_EX;
      end
      S_LA: begin
        cmd.cap    = 1'b1;
        state_next = sts.uses_b ? S_RB : S_EX;
      end
      S_RB: begin
        cmd.res   = 1'b1;
        cmd.sel_b = 1'b1;
        if (sts.res_bad)      state_next = S_DONE;
        else if (sts.res_mem) state_next = S_LB;
        else                  state_next = S_EX;
      end
      S_LB: begin
        cmd.cap    = 1'b1;
        cmd.sel_b  = 1'b1;
        state_next = S_EX;
      end
      S_EX: begin
        cmd.ex = 1'b1;
        case (sts.kind)
          K_DIV:   state_next = S_DIV;
          K_DEC:   state_next = S_FIN2;
          K_SRD:   state_next = S_SRD;
          K_PSH:   state_next = S_PSH;
          default: state_next = S_WB;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin2   = 1'b1;
        state_next = S_WB;
      end
      S_SRD: begin
        cmd.srd    = 1'b1;
        state_next = S_WB;
      end
      S_PSH: begin
        cmd.psh = 1'b1;
        if (sts.psh_last) state_next = S_DONE;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end
endmodule

/* rtl/svm_dp.sv */
module svm_dp #(
  parameter int DATA_WORDS     = svm_pkg::DATA_WORDS_DEF,
  parameter int STACK_DEPTH    = svm_pkg::STACK_DEPTH_DEF,
  parameter int REG_COUNT      = svm_pkg::REG_COUNT_DEF,
  parameter int FLAG_REG_INDEX = svm_pkg::FLAG_REG_INDEX_DEF,
  parameter int PC_BITS        = svm_pkg::PC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  svm_pkg::svm_cmd_t  cmd,
  output svm_pkg::svm_sts_t  sts,
  input  logic [5:0]         command,
  input  logic [2:0]         dest_mode,
  input  logic signed [31:0] dest_operand,
  input  logic [2:0]         src_mode,
  input  logic signed [31:0] src_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        next_pc,
  output logic               char_valid,
  output logic [7:0]         char_out,
  output logic [2:0]         error_code
);
  import svm_pkg::*;

  localparam int DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RAW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int IW  = (DAW > SAW) ? ((DAW > RAW) ? DAW : RAW) : ((SAW > RAW) ? SAW : RAW);

  logic [5:0]         op;
  logic [2:0]         dmode, smode;
  logic [31:0]        dopnd, sopnd;
  logic [31:0]        a, b, r;
  logic [2:0]         err;
  logic [PC_BITS-1:0] pc, nxt, pc_new;
  logic [SCW-1:0]     sc;
  logic [1:0]         la_kind, rk;
  logic [IW-1:0]      la_idx;
  logic               chv;
  logic [7:0]         ch;
  logic [2:0]         dexp;
  logic [31:0]        div_rem, div_q, div_dvs;
  logic [4:0]         div_cnt;
  logic               div_neg;
  logic [SCW-1:0]     psh_cnt;
  logic [DAW-1:0]     clr_addr;
  logic [31:0]        rf [REG_COUNT];

  // Operand resolution
  logic [2:0]  res_mode;
  logic [31:0] res_opnd, rv, res_idx, res_val;
  logic        res_wr, reg_ok;
  logic [2:0]  res_err;
  logic [1:0]  res_kind;

  always_comb begin
    res_mode = cmd.sel_b ? smode : dmode;
    res_opnd = cmd.sel_b ? sopnd : dopnd;
    res_wr   = !cmd.sel_b && writes_a(op);
    reg_ok   = {1'b0, res_opnd} < 33'(REG_COUNT);
    rv       = reg_ok ? rf[res_opnd[RAW-1:0]] : '0;
    res_val  = res_opnd;
    res_idx  = res_opnd;
    res_kind = LOC_IMM;
    res_err  = ERR_NONE;
    unique case (res_mode)
      MODE_IMM: res_err = res_wr ? ERR_MODE : ERR_NONE;
      MODE_MEM: begin
        res_kind = LOC_DATA;
        res_err  = ({1'b0, res_opnd} < 33'(DATA_WORDS)) ? ERR_NONE : ERR_RANGE;
      end
      MODE_REG: begin
        res_kind = LOC_REG;
        res_val  = rv;
        res_err  = reg_ok ? ERR_NONE : ERR_RANGE;
      end
      MODE_RMEM: begin
        res_kind = LOC_DATA;
        res_idx  = rv;
        res_err  = (reg_ok && ({1'b0, rv} < 33'(DATA_WORDS))) ? ERR_NONE : ERR_RANGE;
      end
      MODE_STK: begin
        res_kind = LOC_STK;
        res_err  = ({1'b0, res_opnd} < 33'(STACK_DEPTH)) ? ERR_NONE : ERR_RANGE;
      end
      MODE_RSTK: begin
        res_kind = LOC_STK;
        res_idx  = rv;
        res_err  = (reg_ok && ({1'b0, rv} < 33'(STACK_DEPTH))) ? ERR_NONE : ERR_RANGE;
      end
      default: res_err = ERR_MODE;
    endcase
  end

  // Execute step
  logic [31:0] na, nb, flag_v, ex_r, mx, my, sc32, pk_diff;
  logic [63:0] prod64;
  logic [2:0]  da, db, ex_err, kind;
  logic        da_gt;
  logic signed [33:0] sf_n;
  logic [32:0] pn_sum;
  logic [SAW-1:0] ex_saddr;

  assign na      = a & MANT_MASK;
  assign nb      = b & MANT_MASK;
  assign da      = a[31:29];
  assign db      = b[31:29];
  assign da_gt   = da > db;
  assign sc32    = 32'(sc);
  assign flag_v  = (FLAG_REG_INDEX < REG_COUNT) ? rf[FLAG_REG_INDEX % REG_COUNT] : '0;
  assign sf_n    = $signed(34'(sc)) - $signed({{2{a[31]}}, a});
  assign pn_sum  = 33'(sc) + {1'b0, b};
  assign pk_diff = sc32 - 32'd1 - b;
  assign ex_saddr = (op == OP_PEEK) ? pk_diff[SAW-1:0] : SAW'(sc32 - 32'd1);

  always_comb begin
    unique case (op)
      OP_DMUL: begin mx = na; my = nb; end
      OP_DADD, OP_DSUB: begin
        mx = da_gt ? na : nb;
        my = pow10(da_gt ? (da - db) : (db - da));
      end
      default: begin mx = a; my = b; end
    endcase
  end
  assign prod64 = mx * my;

  always_comb begin
    ex_err = ERR_NONE;
    kind   = K_SIMPLE;
    case (op)
      OP_DIV:  begin if (b == '0) ex_err = ERR_DIV0; else kind = K_DIV; end
      OP_DDIV: begin if (nb == '0) ex_err = ERR_DIV0; else kind = K_DIV; end
      OP_DTOI:  kind = K_DIV;
      OP_DADD, OP_DSUB: kind = K_DEC;
      OP_PUSH:  if (sc >= SCW'(STACK_DEPTH)) ex_err = ERR_OVF;
      OP_POP:   begin if (sc == '0) ex_err = ERR_UNF; else kind = K_SRD; end
      OP_PEEK:  begin if (b >= sc32) ex_err = ERR_UNF; else kind = K_SRD; end
      OP_SFREE: begin
        if (sf_n < 0) ex_err = ERR_UNF;
        else if (sf_n > 34'sd0 + 34'(STACK_DEPTH)) ex_err = ERR_OVF;
      end
      OP_PUSHN: begin
        if (!b[31] && b != '0) begin
          if (pn_sum > 33'(STACK_DEPTH)) ex_err = ERR_OVF;
          else kind = K_PSH;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ex_r = '0;
    case (op)
      OP_MOV:  ex_r = b;
      OP_ADD:  ex_r = a + b;
      OP_SUB:  ex_r = a - b;
      OP_NEG:  ex_r = '0 - a;
      OP_MUL:  ex_r = prod64[31:0];
      OP_DMUL: ex_r = (prod64[31:0] & MANT_MASK) | {da + db, 29'd0};
      OP_EQ:   ex_r = 32'(a == b);
      OP_LAND: ex_r = 32'((a != '0) && (b != '0));
      OP_LOR:  ex_r = 32'((a != '0) || (b != '0));
      OP_AND:  ex_r = a & b;
      OP_OR:   ex_r = a | b;
      OP_GT:   ex_r = 32'($signed(a) > $signed(b));
      OP_GE:   ex_r = 32'($signed(a) >= $signed(b));
      OP_LT:   ex_r = 32'($signed(a) < $signed(b));
      OP_LE:   ex_r = 32'($signed(a) <= $signed(b));
      OP_NE:   ex_r = 32'(a != b);
      OP_LNOT: ex_r = 32'(a == '0);
      OP_SHL:  ex_r = (b >= 32'd32) ? '0 : (a << b[4:0]);
      OP_SHR:  ex_r = (b >= 32'd32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      OP_NOT:  ex_r = ~a;
      OP_GSP:  ex_r = sc32;
      default: ex_r = '0;
    endcase
  end

  // Shared restoring divider, one quotient bit per cycle.
  logic [32:0] div_sh;
  logic        div_ge;
  assign div_sh = {div_rem, div_q[31]};
  assign div_ge = div_sh >= {1'b0, div_dvs};

  logic [31:0] fin_r, dsum;
  assign dsum = (op == OP_DADD) ? (a + b) : (a - b);
  always_comb begin
    case (op)
      OP_DIV:  fin_r = div_neg ? ('0 - div_q) : div_q;
      OP_DDIV: fin_r = {da - db, div_q[28:0]};
      OP_DTOI: fin_r = div_q;
      default: fin_r = {dexp, dsum[28:0]};
    endcase
  end

  // Memories
  logic            dm_we, sm_we;
  logic [DAW-1:0]  dm_waddr;
  logic [31:0]     dm_wdata, dm_rdata, sm_wdata, sm_rdata;
  logic [SAW-1:0]  sm_waddr, sm_raddr;
  logic            wb_ok;

  assign wb_ok    = cmd.wb && (err == ERR_NONE) && writes_a(op);
  assign dm_we    = cmd.clr || (wb_ok && la_kind == LOC_DATA);
  assign dm_waddr = cmd.clr ? clr_addr : la_idx[DAW-1:0];
  assign dm_wdata = cmd.clr ? '0 : r;
  assign sm_we    = (cmd.ex && op == OP_PUSH && ex_err == ERR_NONE) || cmd.psh ||
                    (wb_ok && la_kind == LOC_STK);
  assign sm_waddr = cmd.wb ? la_idx[SAW-1:0] : sc[SAW-1:0];
  assign sm_wdata = cmd.wb ? r : a;
  assign sm_raddr = cmd.ex ? ex_saddr : res_idx[SAW-1:0];

  svm_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(res_idx[DAW-1:0]), .rdata(dm_rdata)
  );

  svm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_smem (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sm_rdata)
  );

  assign pc_new = (err != ERR_NONE) ? (pc + PC_BITS'(1)) : nxt;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      sc        <= '0;
      err       <= ERR_NONE;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) rf[i] <= '0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + DAW'(1);
      if (cmd.dec) err <= (op > OP_PUSHN) ? ERR_OP : ERR_NONE;
      if (cmd.res && res_err != ERR_NONE) err <= res_err;
      if (cmd.ex) begin
        err <= ex_err;
        if (ex_err == ERR_NONE) begin
          if (op == OP_PUSH) sc <= sc + SCW'(1);
          if (op == OP_SFREE) sc <= sf_n[SCW-1:0];
        end
      end
      if (cmd.psh) sc <= sc + SCW'(1);
      if (cmd.wb && err == ERR_NONE && op == OP_POP) sc <= sc - SCW'(1);
      if (wb_ok && la_kind == LOC_REG) rf[la_idx[RAW-1:0]] <= r;
      if (cmd.done) begin
        pc        <= pc_new;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= command;
      dmode <= dest_mode;
      dopnd <= dest_operand;
      smode <= src_mode;
      sopnd <= src_operand;
    end
    if (cmd.dec) begin
      nxt <= pc + PC_BITS'(1);
      chv <= 1'b0;
      ch  <= '0;
    end
    if (cmd.res) begin
      rk <= res_kind;
      if (cmd.sel_b) begin
        b <= res_val;
      end else begin
        a       <= res_val;
        la_kind <= res_kind;
        la_idx  <= res_idx[IW-1:0];
      end
    end
    if (cmd.cap) begin
      if (cmd.sel_b) b <= (rk == LOC_DATA) ? dm_rdata : sm_rdata;
      else           a <= (rk == LOC_DATA) ? dm_rdata : sm_rdata;
    end
    if (cmd.ex) begin
      r <= ex_r;
      if (op == OP_JMP || (op == OP_JMPC && flag_v == '0)) nxt <= pc + a[PC_BITS-1:0];
      if (op == OP_PUTC) begin
        chv <= 1'b1;
        ch  <= a[7:0];
      end
      if (op == OP_DADD || op == OP_DSUB) begin
        // Bring both mantissas to the smaller exponent.
        a    <= da_gt ? prod64[31:0] : na;
        b    <= da_gt ? nb : prod64[31:0];
        dexp <= da_gt ? db : da;
      end
      div_rem <= '0;
      div_cnt <= '0;
      div_neg <= a[31] ^ b[31];
      case (op)
        OP_DIV: begin
          div_q   <= a[31] ? ('0 - a) : a;
          div_dvs <= b[31] ? ('0 - b) : b;
        end
        OP_DDIV: begin div_q <= na; div_dvs <= nb; end
        default: begin div_q <= nb; div_dvs <= pow10(db); end
      endcase
      psh_cnt <= b[SCW-1:0];
    end
    if (cmd.div_step) begin
      div_rem <= div_ge ? 32'(div_sh - {1'b0, div_dvs}) : div_sh[31:0];
      div_q   <= {div_q[30:0], div_ge};
      div_cnt <= div_cnt + 5'd1;
    end
    if (cmd.fin2) r <= fin_r;
    if (cmd.srd)  r <= sm_rdata;
    if (cmd.psh)  psh_cnt <= psh_cnt - SCW'(1);
    if (cmd.done) begin
      next_pc    <= 16'(pc_new);
      char_valid <= chv && (err == ERR_NONE);
      char_out   <= (err == ERR_NONE) ? ch : 8'd0;
      error_code <= err;
    end
  end

  assign sts.clr_last = (clr_addr == DAW'(DATA_WORDS - 1));
  assign sts.op_bad   = op > OP_PUSHN;
  assign sts.op_nop   = op == OP_NOP;
  assign sts.uses_b   = reads_b(op);
  assign sts.res_bad  = res_err != ERR_NONE;
  assign sts.res_mem  = (res_kind == LOC_DATA) || (res_kind == LOC_STK);
  assign sts.kind     = (ex_err != ERR_NONE) ? K_SIMPLE : kind;
  assign sts.div_last = div_cnt == 5'd31;
  assign sts.psh_last = psh_cnt == SCW'(1);
  assign sts.out_busy = out_valid && !out_ready;
endmodule

/* rtl/svm_chk.sv */
module svm_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] next_pc,
  input logic        char_valid,
  input logic [2:0]  error_code
);
  import svm_pkg::*;

  // Only one request is ever in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> error_code == ERR_NONE)
    else $error("character reported with an error");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code != 3'd7)
    else $error("undefined error code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc))
    else $error("stalled result changed");
endmodule

bind stack_vm_instruction_executor_core svm_chk u_svm_chk (.*);

/* tb/svm_checker.sv */
`timescale 1ns / 1ps
module svm_checker
  import svm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [5:0]  command,
  input  logic [2:0]  dest_mode,
  input  logic [31:0] dest_operand,
  input  logic [2:0]  src_mode,
  input  logic [31:0] src_operand,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] next_pc,
  input  logic        char_valid,
  input  logic [7:0]  char_out,
  input  logic [2:0]  error_code,
  output int          mismatches,
  output int          pending
);

  localparam int NWORDS = DATA_WORDS_DEF;
  localparam int NSLOTS = STACK_DEPTH_DEF;
  localparam int NREGS  = REG_COUNT_DEF;

  typedef struct packed {
    logic [15:0] pc;
    logic        cv;
    logic [7:0]  ch;
    logic [2:0]  err;
  } outcome_t;

  logic [15:0] pc;
  logic [31:0] dmem [NWORDS];
  logic [31:0] regs [NREGS];
  logic [31:0] stk  [NSLOTS];
  int          depth;
  outcome_t    outcomes_due [$];

  function automatic logic [31:0] ten_to(input logic [2:0] e);
    logic [31:0] v;
    v = 32'd1;
    for (int i = 0; i < e; i++) v = v * 32'd10;
    return v;
  endfunction

  function automatic logic [2:0] locate(input logic [2:0] m, input logic [31:0] opnd,
                                        input logic wrt, output logic [1:0] kind,
                                        output logic [31:0] idx);
    kind = LOC_IMM;
    idx  = 32'd0;
    case (m)
      MODE_IMM: return wrt ? ERR_MODE : ERR_NONE;
      MODE_MEM: begin
        kind = LOC_DATA; idx = opnd;
        return (opnd < NWORDS) ? ERR_NONE : ERR_RANGE;
      end
      MODE_REG: begin
        kind = LOC_REG; idx = opnd;
        return (opnd < NREGS) ? ERR_NONE : ERR_RANGE;
      end
      MODE_RMEM: begin
        if (opnd >= NREGS) return ERR_RANGE;
        kind = LOC_DATA; idx = regs[opnd];
        return (idx < NWORDS) ? ERR_NONE : ERR_RANGE;
      end
      MODE_STK: begin
        kind = LOC_STK; idx = opnd;
        return (opnd < NSLOTS) ? ERR_NONE : ERR_RANGE;
      end
      MODE_RSTK: begin
        if (opnd >= NREGS) return ERR_RANGE;
        kind = LOC_STK; idx = regs[opnd];
        return (idx < NSLOTS) ? ERR_NONE : ERR_RANGE;
      end
      default: return ERR_MODE;
    endcase
  endfunction

  function automatic logic [31:0] fetch(input logic [1:0] kind, input logic [31:0] idx,
                                        input logic [31:0] imm);
    case (kind)
      LOC_DATA: return dmem[idx % NWORDS];
      LOC_REG:  return regs[idx % NREGS];
      LOC_STK:  return stk[idx % NSLOTS];
      default:  return imm;
    endcase
  endfunction

  function automatic void store(input logic [1:0] kind, input logic [31:0] idx,
                                input logic [31:0] v);
    case (kind)
      LOC_DATA: dmem[idx % NWORDS] = v;
      LOC_REG:  regs[idx % NREGS] = v;
      LOC_STK:  stk[idx % NSLOTS] = v;
      default: ;
    endcase
  endfunction

  function automatic outcome_t execute(input logic [5:0] op, input logic [2:0] dm,
                                       input logic [31:0] ao, input logic [2:0] sm,
                                       input logic [31:0] bo);
    outcome_t    o;
    logic [15:0] nxt;
    logic [31:0] a, b, r, na, nb, ib;
    logic [2:0]  err, da, db;
    logic [1:0]  ka, kb;
    logic        wa, ub, dowr;
    longint      sa, sb, n;
    a = 0; b = 0; r = 0; ka = LOC_IMM; ib = 0;
    err = ERR_NONE;
    dowr = 1'b1;
    o = '0;
    nxt = pc + 16'd1;
    wa = !(op inside {OP_NOP, OP_JMP, OP_JMPC, OP_PUSH, OP_SFREE, OP_PUTC, OP_PUSHN});
    ub = op inside {OP_MOV, OP_ADD, OP_SUB, [OP_MUL:OP_EQ], OP_PEEK, [OP_LAND:OP_NE],
                    OP_SHL, OP_SHR, OP_DTOI, OP_PUSHN};
    if (op > OP_PUSHN) err = ERR_OP;
    if (err == ERR_NONE && op != OP_NOP) begin
      err = locate(dm, ao, wa, ka, ib);
      if (err == ERR_NONE) a = fetch(ka, ib, ao);
    end
    if (err == ERR_NONE && ub) begin
      logic [31:0] jb;
      err = locate(sm, bo, 1'b0, kb, jb);
      if (err == ERR_NONE) b = fetch(kb, jb, bo);
    end
    if (err == ERR_NONE) begin
      na = a & MANT_MASK;
      nb = b & MANT_MASK;
      da = a[31:29];
      db = b[31:29];
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      case (op)
        OP_NOP: dowr = 1'b0;
        OP_MOV: r = b;
        OP_ADD: r = a + b;
        OP_SUB: r = a - b;
        OP_NEG: r = 32'd0 - a;
        OP_MUL: r = a * b;
        OP_DIV: begin
          if (b == 0) err = ERR_DIV0;
          else r = 32'(sa / sb);
        end
        OP_DADD, OP_DSUB: begin
          if (da > db) begin
            na = na * ten_to(da - db);
            da = db;
          end else begin
            nb = nb * ten_to(db - da);
          end
          r = (((op == OP_DADD) ? na + nb : na - nb) & MANT_MASK) | {da, 29'd0};
        end
        OP_DMUL: r = ((na * nb) & MANT_MASK) | {3'(da + db), 29'd0};
        OP_DDIV: begin
          if (nb == 0) err = ERR_DIV0;
          else r = ((na / nb) & MANT_MASK) | {3'(da - db), 29'd0};
        end
        OP_EQ: r = 32'(a == b);
        OP_JMP: begin
          nxt = pc + a[15:0];
          dowr = 1'b0;
        end
        OP_JMPC: begin
          if (regs[FLAG_REG_INDEX_DEF] == 0) nxt = pc + a[15:0];
          dowr = 1'b0;
        end
        OP_PUSH: begin
          if (depth >= NSLOTS) err = ERR_OVF;
          else begin
            stk[depth] = a;
            depth++;
          end
          dowr = 1'b0;
        end
        OP_POP: begin
          if (depth == 0) err = ERR_UNF;
          else begin
            store(ka, ib, stk[depth - 1]);
            depth--;
          end
          dowr = 1'b0;
        end
        OP_PEEK: begin
          if (b >= depth) err = ERR_UNF;
          else r = stk[depth - 1 - b];
        end
        OP_SFREE: begin
          n = longint'(depth) - sa;
          if (n < 0) err = ERR_UNF;
          else if (n > NSLOTS) err = ERR_OVF;
          else depth = int'(n);
          dowr = 1'b0;
        end
        OP_LAND: r = 32'(a != 0 && b != 0);
        OP_LOR:  r = 32'(a != 0 || b != 0);
        OP_AND:  r = a & b;
        OP_OR:   r = a | b;
        OP_GT:   r = 32'(sa > sb);
        OP_GE:   r = 32'(sa >= sb);
        OP_LT:   r = 32'(sa < sb);
        OP_LE:   r = 32'(sa <= sb);
        OP_NE:   r = 32'(a != b);
        OP_PUTC: begin
          o.cv = 1'b1;
          o.ch = a[7:0];
          dowr = 1'b0;
        end
        OP_LNOT: r = 32'(a == 0);
        OP_SHL:  r = (b >= 32) ? 32'd0 : (a << b);
        OP_SHR:  r = (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b);
        OP_NOT:  r = ~a;
        OP_DTOI: r = nb / ten_to(db);
        OP_GSP:  r = 32'(depth);
        default: begin
          // Repeated push: all or nothing.
          if (sb > 0) begin
            if (longint'(depth) + sb > NSLOTS) err = ERR_OVF;
            else for (longint i = 0; i < sb; i++) begin
              stk[depth] = a;
              depth++;
            end
          end
          dowr = 1'b0;
        end
      endcase
      if (err == ERR_NONE && dowr) store(ka, ib, r);
    end
    if (err != ERR_NONE) begin
      o.cv = 1'b0;
      o.ch = 8'd0;
      nxt = pc + 16'd1;
    end
    pc = nxt;
    o.pc = nxt;
    o.err = err;
    return o;
  endfunction

  assign pending = outcomes_due.size();

  always @(posedge clk) begin
    outcome_t want, got;
    if (rst) begin
      pc = 16'd0;
      depth = 0;
      foreach (dmem[i]) dmem[i] = 32'd0;
      foreach (regs[i]) regs[i] = 32'd0;
      foreach (stk[i]) stk[i] = 32'd0;
      outcomes_due.delete();
      mismatches <= 0;
    end else begin
      // The result always belongs to an earlier request, so retire before predicting.
      if (out_valid && out_ready) begin
        got = '{next_pc, char_valid, char_out, error_code};
        if (outcomes_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("%t: result with nothing outstanding: pc=%h cv=%b ch=%h err=%0d",
                     $realtime, got.pc, got.cv, got.ch, got.err);
        end else begin
          want = outcomes_due.pop_front();
          if (want !== got) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("%t: mismatch: expected pc=%h cv=%b ch=%h err=%0d, got pc=%h cv=%b ch=%h err=%0d",
                       $realtime, want.pc, want.cv, want.ch, want.err,
                       got.pc, got.cv, got.ch, got.err);
          end
        end
      end
      if (in_valid && in_ready)
        outcomes_due.push_back(execute(command, dest_mode, dest_operand, src_mode,
                                       src_operand));
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import svm_pkg::*;

  localparam int RANDOM_ITEMS = 1480;
  localparam int CALM_FROM    = 1250;
  localparam int CYCLE_LIMIT  = 800000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [5:0]  command = '0;
  logic [2:0]  dest_mode = '0;
  logic [31:0] dest_operand = '0;
  logic [2:0]  src_mode = '0;
  logic [31:0] src_operand = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] next_pc;
  logic        char_valid;
  logic [7:0]  char_out;
  logic [2:0]  error_code;
  int          mismatches;
  int          pending;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          long_hold = 1'b0;

  stack_vm_instruction_executor_core dut (
    .clk, .rst, .in_valid, .in_ready, .command, .dest_mode, .dest_operand,
    .src_mode, .src_operand, .out_valid, .out_ready, .next_pc, .char_valid,
    .char_out, .error_code
  );

  svm_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .command, .dest_mode, .dest_operand,
    .src_mode, .src_operand, .out_valid, .out_ready, .next_pc, .char_valid,
    .char_out, .error_code, .mismatches, .pending
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** stack_vm_instruction_executor_core: FAILED **");
      $finish;
    end
  end

  // Result side: random back-pressure bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic issue(input logic [5:0] op, input logic [2:0] dm, input logic [31:0] ao,
                       input logic [2:0] sm, input logic [31:0] bo);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= op;
    dest_mode <= dm;
    dest_operand <= ao;
    src_mode <= sm;
    src_operand <= bo;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] pick_operand(input logic [2:0] m);
    case (m)
      MODE_IMM: begin
        case ($urandom_range(0, 3))
          0: return $urandom;
          1: return 32'($urandom_range(0, 44)) - 32'd4;
          2: begin
            case ($urandom_range(0, 3))
              0: return 32'h8000_0000;
              1: return 32'h7FFF_FFFF;
              2: return 32'hFFFF_FFFF;
              default: return 32'd0;
            endcase
          end
          default: return $urandom_range(0, 8);
        endcase
      end
      MODE_MEM, MODE_STK:
        return ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 255);
      MODE_REG, MODE_RMEM, MODE_RSTK:
        return ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [5:0] op;
    logic [2:0] dm, sm;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Fill every stack slot once so that later stack reads always hit written words.
    issue(OP_PUSHN, MODE_IMM, 32'h5A5A_0001, MODE_IMM, 32'd256);
    issue(OP_PUSH,  MODE_IMM, 32'd7, MODE_IMM, 32'd0);
    issue(OP_SFREE, MODE_IMM, 32'd256, MODE_IMM, 32'd0);
    issue(OP_POP,   MODE_REG, 32'd3, MODE_IMM, 32'd0);
    issue(OP_SFREE, MODE_IMM, 32'hFFFF_FFFF, MODE_IMM, 32'd0);
    issue(OP_PEEK,  MODE_REG, 32'd2, MODE_IMM, 32'd0);
    issue(OP_PEEK,  MODE_REG, 32'd2, MODE_IMM, 32'd1);
    issue(OP_PUSHN, MODE_IMM, 32'd1, MODE_IMM, 32'd300);
    issue(OP_SFREE, MODE_IMM, 32'h8000_0000, MODE_IMM, 32'd0);
    issue(OP_NOP,   MODE_IMM, 32'd0, MODE_IMM, 32'd0);
    issue(OP_MOV,   MODE_REG, 32'd1, MODE_IMM, {3'd2, 29'd150});
    issue(OP_DADD,  MODE_REG, 32'd1, MODE_IMM, {3'd5, 29'h1FFF_FFFF});
    issue(OP_DDIV,  MODE_REG, 32'd1, MODE_IMM, {3'd7, 29'd0});
    issue(OP_DTOI,  MODE_REG, 32'd1, MODE_IMM, {3'd7, 29'd123456789});
    issue(OP_MOV,   MODE_REG, 32'd4, MODE_IMM, 32'h8000_0000);
    issue(OP_DIV,   MODE_REG, 32'd4, MODE_IMM, 32'hFFFF_FFFF);
    issue(OP_DIV,   MODE_REG, 32'd4, MODE_IMM, 32'd0);
    issue(OP_SHR,   MODE_REG, 32'd4, MODE_IMM, 32'd40);
    issue(OP_SHL,   MODE_MEM, 32'd255, MODE_IMM, 32'd32);
    issue(OP_MOV,   MODE_IMM, 32'd0, MODE_IMM, 32'd1);
    issue(OP_MOV,   MODE_MEM, 32'd256, MODE_IMM, 32'd1);
    issue(OP_ADD,   MODE_RMEM, 32'd8, MODE_IMM, 32'd1);
    issue(6'd63,    3'd7, 32'd0, 3'd6, 32'd0);
    issue(OP_ADD,   MODE_REG, 32'd0, 3'd7, 32'd0);
    issue(OP_JMPC,  MODE_IMM, 32'hFFFF_FFF0, MODE_IMM, 32'd0);
    issue(OP_PUTC,  MODE_IMM, 32'h1234_56C3, MODE_IMM, 32'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      if (i == 300) long_hold = 1'b1;
      if (i == 600) begin
        // Let the block drain completely before carrying on.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if ($urandom_range(0, 5) == 0) begin
        // Keep registers small so that indirect modes mostly land in range.
        issue(OP_MOV, MODE_REG, $urandom_range(0, 7), MODE_IMM, $urandom_range(0, 255));
      end else begin
        op = ($urandom_range(0, 24) == 0) ? 6'($urandom_range(35, 63))
                                          : 6'($urandom_range(0, 34));
        dm = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
        sm = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
        issue(op, dm, pick_operand(dm), sm, pick_operand(sm));
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("** stack_vm_instruction_executor_core: PASSED **");
    end else begin
      $display("** stack_vm_instruction_executor_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/svm_pkg.sv
rtl/svm_ram.sv
rtl/svm_ctrl.sv
rtl/svm_dp.sv
rtl/stack_vm_instruction_executor_core.sv
rtl/svm_chk.sv
tb/svm_checker.sv
tb/tb.sv
